@@ sv/block_buffer_cache_lru_macros.svh @@
// assertion macros used by the checker file
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// clocked assertion, off while reset is held
`define BBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, checked in reset too
`define BBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/bbc_pkg.sv @@
package bbc_pkg;

  localparam int ENTRIES_DEF   = 32;
  localparam int TICK_BITS_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int DEV_W    = 8;
  localparam int BLK_W    = 32;
  localparam int IDXF_W   = 5;
  localparam int NOW_W    = 32;
  localparam int CNT_W    = 8;
  localparam int STATUS_W = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET   = 2'd0,
    FUNC_REL   = 2'd1,
    FUNC_PIN   = 2'd2,
    FUNC_UNPIN = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_NOFREE = 2'd2,
    ST_UNDER  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISP,
    S_SCAN,
    S_PICK,
    S_APPLY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan;
    logic fetch_req;
    logic fetch_pick;
    logic apply;
    logic reject;
  } cmd_t;

  typedef struct packed {
    logic is_get;
    logic scan_done;
    logic none_free;
  } sts_t;

endpackage

@@ sv/bbc_req_if.sv @@
interface bbc_req_if;
  import bbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [DEV_W-1:0]  device_id;
  logic [BLK_W-1:0]  block_number;
  logic [IDXF_W-1:0] entry_index;
  logic [NOW_W-1:0]  now_tick;

  modport source (
    output valid, func, device_id, block_number, entry_index, now_tick,
    input  ready
  );
  modport sink (
    input  valid, func, device_id, block_number, entry_index, now_tick,
    output ready
  );
endinterface

@@ sv/bbc_rsp_if.sv @@
interface bbc_rsp_if;
  import bbc_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDXF_W-1:0]   entry_out;
  logic [STATUS_W-1:0] status;
  logic                need_fill;
  logic [CNT_W-1:0]    ref_count_out;

  modport source (
    output valid, entry_out, status, need_fill, ref_count_out,
    input  ready
  );
  modport sink (
    input  valid, entry_out, status, need_fill, ref_count_out,
    output ready
  );
endinterface

@@ sv/bbc_ctrl.sv @@
module bbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bbc_pkg::sts_t sts_i,
  output bbc_pkg::cmd_t cmd_o
);
  import bbc_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISP;
      end
      S_DISP: begin
        state_d = sts_i.is_get ? S_SCAN : S_APPLY;
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_PICK;
      end
      S_PICK: begin
        state_d = sts_i.none_free ? S_DONE : S_APPLY;
      end
      S_APPLY: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      S_DISP: begin
        cmd_o.scan_start = sts_i.is_get;
        cmd_o.fetch_req  = !sts_i.is_get;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      S_PICK: begin
        cmd_o.reject     = sts_i.none_free;
        cmd_o.fetch_pick = !sts_i.none_free;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
      end
      S_DONE: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/bbc_datapath.sv @@
module bbc_datapath #(
  parameter int ENTRIES   = bbc_pkg::ENTRIES_DEF,
  parameter int TICK_BITS = bbc_pkg::TICK_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  bbc_pkg::cmd_t                    cmd_i,
  output bbc_pkg::sts_t                    sts_o,
  input  logic [bbc_pkg::FUNC_W-1:0]       func_i,
  input  logic [bbc_pkg::DEV_W-1:0]        device_id_i,
  input  logic [bbc_pkg::BLK_W-1:0]        block_number_i,
  input  logic [bbc_pkg::IDXF_W-1:0]       entry_index_i,
  input  logic [bbc_pkg::NOW_W-1:0]        now_tick_i,
  output logic [bbc_pkg::IDXF_W-1:0]       entry_out_o,
  output logic [bbc_pkg::STATUS_W-1:0]     status_o,
  output logic                             need_fill_o,
  output logic [bbc_pkg::CNT_W-1:0]        ref_count_out_o
);
  import bbc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  typedef struct packed {
    logic                 cv;
    logic [DEV_W-1:0]     dev;
    logic [BLK_W-1:0]     blk;
    logic [CNT_W-1:0]     cnt;
    logic [TICK_BITS-1:0] rtime;
  } row_t;

  // request registers
  func_e                req_func_q;
  logic [DEV_W-1:0]     req_dev_q;
  logic [BLK_W-1:0]     req_blk_q;
  logic [IDXF_W-1:0]    req_idx_q;
  logic [TICK_BITS-1:0] req_tick_q;

  // entry memory and valid bits
  row_t               mem [ENTRIES];
  row_t               rd_q;
  logic               rv_q;
  logic [ENTRIES-1:0] row_vld_q;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  row_t               wr_row;
  row_t               rd_row;

  // scan state
  logic [IDX_W:0]       scan_cnt_q;
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic                 found_q;
  logic [IDX_W-1:0]     vic_idx_q;
  logic [TICK_BITS-1:0] best_q;
  logic [IDX_W-1:0]     ev_idx;
  logic                 scan_done;
  logic [IDX_W-1:0]     tgt_q;
  logic [IDX_W-1:0]     tgt_d;

  // result registers
  logic [IDXF_W-1:0] res_entry_q, res_entry_d;
  status_e           res_status_q, res_status_d;
  logic              res_fill_q, res_fill_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;

  logic bad_idx;

  assign bad_idx   = int'(req_idx_q) >= ENTRIES;
  assign scan_done = scan_cnt_q == (IDX_W+1)'(ENTRIES);
  assign ev_idx    = IDX_W'(scan_cnt_q - (IDX_W+1)'(1));
  assign rd_row    = rv_q ? rd_q : '0;

  assign sts_o.is_get    = req_func_q == FUNC_GET;
  assign sts_o.scan_done = scan_done;
  assign sts_o.none_free = !hit_q && !found_q;

  always_comb begin
    tgt_d   = tgt_q;
    rd_en   = 1'b0;
    rd_addr = scan_cnt_q[IDX_W-1:0];
    if (cmd_i.fetch_req) begin
      tgt_d = IDX_W'(req_idx_q);
    end else if (cmd_i.fetch_pick) begin
      tgt_d = hit_q ? hit_idx_q : vic_idx_q;
    end
    if (cmd_i.fetch_req || cmd_i.fetch_pick) begin
      rd_en   = 1'b1;
      rd_addr = tgt_d;
    end else if (cmd_i.scan && !scan_done) begin
      rd_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[tgt_q] <= wr_row;
    if (rd_en) begin
      rd_q <= mem[rd_addr];
      rv_q <= row_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
    end else if (wr_en) begin
      row_vld_q[tgt_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_func_q <= func_e'(func_i);
      req_dev_q  <= device_id_i;
      req_blk_q  <= block_number_i;
      req_idx_q  <= entry_index_i;
      req_tick_q <= TICK_BITS'(now_tick_i);
    end
    tgt_q <= tgt_d;
    if (cmd_i.apply || cmd_i.reject) begin
      res_entry_q  <= res_entry_d;
      res_status_q <= res_status_d;
      res_fill_q   <= res_fill_d;
      res_cnt_q    <= res_cnt_d;
    end
  end

  // one entry compared per cycle, first valid match and oldest free entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      hit_q      <= 1'b0;
      found_q    <= 1'b0;
      hit_idx_q  <= '0;
      vic_idx_q  <= '0;
      best_q     <= '0;
    end else if (cmd_i.scan_start) begin
      scan_cnt_q <= '0;
      hit_q      <= 1'b0;
      found_q    <= 1'b0;
    end else if (cmd_i.scan) begin
      if (!scan_done) scan_cnt_q <= scan_cnt_q + (IDX_W+1)'(1);
      if (scan_cnt_q != '0) begin
        if (!hit_q && rd_row.cv && rd_row.dev == req_dev_q && rd_row.blk == req_blk_q) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ev_idx;
        end
        if (rd_row.cnt == '0 && (!found_q || rd_row.rtime < best_q)) begin
          found_q   <= 1'b1;
          vic_idx_q <= ev_idx;
          best_q    <= rd_row.rtime;
        end
      end
    end
  end

  always_comb begin
    wr_row       = rd_row;
    wr_en        = 1'b0;
    res_entry_d  = req_idx_q;
    res_status_d = ST_HIT;
    res_fill_d   = 1'b0;
    res_cnt_d    = '0;
    case (req_func_q) inside
      FUNC_GET: begin
        res_entry_d = IDXF_W'(tgt_q);
        wr_en       = cmd_i.apply;
        if (hit_q) begin
          wr_row.cnt = (rd_row.cnt == CNT_MAX) ? rd_row.cnt : rd_row.cnt + CNT_W'(1);
          res_cnt_d  = wr_row.cnt;
        end else begin
          wr_row.cv    = 1'b1;
          wr_row.dev   = req_dev_q;
          wr_row.blk   = req_blk_q;
          wr_row.cnt   = CNT_W'(1);
          res_status_d = ST_MISS;
          res_fill_d   = 1'b1;
          res_cnt_d    = CNT_W'(1);
        end
      end
      FUNC_PIN: begin
        if (bad_idx) begin
          res_status_d = ST_UNDER;
        end else begin
          wr_en      = cmd_i.apply;
          wr_row.cnt = (rd_row.cnt == CNT_MAX) ? rd_row.cnt : rd_row.cnt + CNT_W'(1);
          res_cnt_d  = wr_row.cnt;
        end
      end
      FUNC_REL, FUNC_UNPIN: begin
        if (bad_idx || rd_row.cnt == '0) begin
          res_status_d = ST_UNDER;
        end else begin
          wr_en      = cmd_i.apply;
          wr_row.cnt = rd_row.cnt - CNT_W'(1);
          res_cnt_d  = wr_row.cnt;
          // final release records when the entry went free
          if (req_func_q == FUNC_REL && wr_row.cnt == '0) wr_row.rtime = req_tick_q;
        end
      end
    endcase
    if (cmd_i.reject) begin
      res_entry_d  = '0;
      res_status_d = ST_NOFREE;
      res_fill_d   = 1'b0;
      res_cnt_d    = '0;
    end
  end

  assign entry_out_o     = res_entry_q;
  assign status_o        = res_status_q;
  assign need_fill_o     = res_fill_q;
  assign ref_count_out_o = res_cnt_q;

endmodule

@@ sv/block_buffer_cache_lru.sv @@
// get: dispatch, entry scan, pick and apply come between the taken item and the valid result,
// with no apply when no entry is free; release, pin, unpin: dispatch and apply come between them
// one item at a time, one memory read per entry scanned: the controller returns to idle once the
// result is taken and only then takes the next item
// reset clears controller, scan state and entry valid bits at once; unwritten entries read zero
module block_buffer_cache_lru #(
  parameter int ENTRIES   = bbc_pkg::ENTRIES_DEF,
  parameter int TICK_BITS = bbc_pkg::TICK_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bbc_req_if.sink   req_i,
  bbc_rsp_if.source rsp_o
);
  import bbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbc_datapath #(
    .ENTRIES   (ENTRIES),
    .TICK_BITS (TICK_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .func_i          (req_i.func),
    .device_id_i     (req_i.device_id),
    .block_number_i  (req_i.block_number),
    .entry_index_i   (req_i.entry_index),
    .now_tick_i      (req_i.now_tick),
    .entry_out_o     (rsp_o.entry_out),
    .status_o        (rsp_o.status),
    .need_fill_o     (rsp_o.need_fill),
    .ref_count_out_o (rsp_o.ref_count_out)
  );

endmodule

@@ sv/bbc_checker.sv @@
`include "block_buffer_cache_lru_macros.svh"

module bbc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            req_valid_i,
  input logic                            req_ready_i,
  input logic                            rsp_valid_i,
  input logic                            rsp_ready_i,
  input logic [bbc_pkg::IDXF_W-1:0]      entry_out_i,
  input logic [bbc_pkg::STATUS_W-1:0]    status_i,
  input logic                            need_fill_i,
  input logic [bbc_pkg::CNT_W-1:0]       ref_count_out_i
);
  import bbc_pkg::*;

  // a pending result holds until taken
  `BBC_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "result dropped")

  // no new item while a result waits
  `BBC_ASSERT(a_one_item, rsp_valid_i |-> !req_ready_i, "item taken with result pending")

  // a taken request always passes through dispatch before its result is valid
  `BBC_ASSERT(a_min_lat, req_valid_i && req_ready_i |=> !rsp_valid_i, "result too early")

  // a miss always asks for a fill and holds the entry once
  `BBC_ASSERT(a_miss, rsp_valid_i && status_i == ST_MISS |-> need_fill_i &&
    ref_count_out_i == CNT_W'(1), "bad miss result")

  // no free buffer carries an empty result
  `BBC_ASSERT(a_nofree, rsp_valid_i && status_i == ST_NOFREE |-> entry_out_i == '0 &&
    !need_fill_i && ref_count_out_i == '0, "bad no-free result")

endmodule

bind block_buffer_cache_lru bbc_checker u_bbc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .entry_out_i     (rsp_o.entry_out),
  .status_i        (rsp_o.status),
  .need_fill_i     (rsp_o.need_fill),
  .ref_count_out_i (rsp_o.ref_count_out)
);
